// ----- hdl/btfa_pkg.sv -----
// Shared constants, types and trit helper functions for the balanced ternary float ALU.
package btfa_pkg;

    localparam int TRITS  = 32;
    localparam int MANT_W = 64;
    localparam int EXP_W  = 8;
    localparam int KIND_W = 2;

    // carry-propagate slice width, in trits
    localparam int CHUNK  = 8;
    // working width: product plus two guard trits, padded to whole slices
    localparam int WORK   = 2 * TRITS + 2;
    localparam int NCHUNK = (WORK + CHUNK - 1) / CHUNK;
    localparam int WP     = NCHUNK * CHUNK;

    localparam int SH_W    = $clog2(TRITS);
    localparam int CNT_MAX = (TRITS > NCHUNK) ? TRITS : NCHUNK;
    localparam int CNT_W   = $clog2(CNT_MAX);

    localparam logic [KIND_W-1:0] KIND_ADD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SUB = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NEG = 2'd2;
    localparam logic [KIND_W-1:0] KIND_MUL = 2'd3;

    localparam logic [1:0] TRIT_ZERO = 2'b00;
    localparam logic [1:0] TRIT_POS  = 2'b01;
    localparam logic [1:0] TRIT_NEG  = 2'b11;

    typedef logic signed [2:0] t_tval;

    typedef struct packed {
        logic [1:0] t;   // digit kept in place
        logic [1:0] k;   // carry into next position
    } t_digit;

    typedef struct packed {
        logic load;
        logic mul_step;
        logic prop_step;
    } t_cmd;

    function automatic t_tval trit_val(input logic [1:0] c);
        t_tval v;
        if (c == TRIT_POS) begin
            v = 3'sd1;
        end else if (c == TRIT_NEG) begin
            v = -3'sd1;
        end else begin
            v = 3'sd0;
        end
        return v;
    endfunction

    function automatic logic [1:0] trit_code(input t_tval v);
        logic [1:0] c;
        if (v == 3'sd1) begin
            c = TRIT_POS;
        end else if (v == -3'sd1) begin
            c = TRIT_NEG;
        end else begin
            c = TRIT_ZERO;
        end
        return c;
    endfunction

    function automatic logic [1:0] trit_neg(input logic [1:0] c);
        return trit_code(-trit_val(c));
    endfunction

    // x in -3..3 becomes t + 3*k with t, k balanced trits
    function automatic t_digit trit_split(input t_tval x);
        t_digit d;
        if (x > 3'sd1) begin
            d.t = trit_code(x - 3'sd3);
            d.k = TRIT_POS;
        end else if (x < -3'sd1) begin
            d.t = trit_code(x + 3'sd3);
            d.k = TRIT_NEG;
        end else begin
            d.t = trit_code(x);
            d.k = TRIT_ZERO;
        end
        return d;
    endfunction

endpackage

// ----- hdl/balanced_ternary_float_alu_unit.sv -----
// Top level of the balanced ternary float ALU: controller plus datapath.
//
//  channel   signals                                    direction  handshake
//  request   start, i_kind, i_a_mant, i_a_exp,          in         start & !busy
//            i_b_mant, i_b_exp
//  result    o_valid, o_res_mant, o_res_exp, o_overflow  out        o_valid, one cycle
//
// Add, subtract, negate: the request edge loads the aligned operands, then
// NCHUNK (9) steps of 8-trit carry propagation and a result state.
// Multiply adds TRITS (32) carry-save partial-product steps first.
// busy stays high from the request edge until the result strobe has gone.
// Synchronous active-low reset clears the sequencer only; results cannot be stalled.
module balanced_ternary_float_alu_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [btfa_pkg::KIND_W-1:0]         i_kind,
    input  logic [btfa_pkg::MANT_W-1:0]         i_a_mant,
    input  logic signed [btfa_pkg::EXP_W-1:0]   i_a_exp,
    input  logic [btfa_pkg::MANT_W-1:0]         i_b_mant,
    input  logic signed [btfa_pkg::EXP_W-1:0]   i_b_exp,
    output logic                                o_valid,
    output logic [btfa_pkg::MANT_W-1:0]         o_res_mant,
    output logic signed [btfa_pkg::EXP_W-1:0]   o_res_exp,
    output logic                                o_overflow
);

    btfa_pkg::t_cmd cmd;

    btfa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_kind  (i_kind),
        .busy    (busy),
        .o_valid (o_valid),
        .o_cmd   (cmd)
    );

    btfa_dp u_dp (
        .i_clk      (i_clk),
        .i_cmd      (cmd),
        .i_kind     (i_kind),
        .i_a_mant   (i_a_mant),
        .i_a_exp    (i_a_exp),
        .i_b_mant   (i_b_mant),
        .i_b_exp    (i_b_exp),
        .o_res_mant (o_res_mant),
        .o_res_exp  (o_res_exp),
        .o_overflow (o_overflow)
    );

endmodule

// ----- hdl/btfa_ctrl.sv -----
// Sequencer for the balanced ternary ALU: load, multiply steps, carry propagation, result strobe.
module btfa_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    input  logic [btfa_pkg::KIND_W-1:0]  i_kind,
    output logic                         busy,
    output logic                         o_valid,
    output btfa_pkg::t_cmd               o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_PROP = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    localparam logic [btfa_pkg::CNT_W-1:0] MUL_LAST =
        btfa_pkg::CNT_W'(btfa_pkg::TRITS - 1);
    localparam logic [btfa_pkg::CNT_W-1:0] PROP_LAST =
        btfa_pkg::CNT_W'(btfa_pkg::NCHUNK - 1);

    logic [1:0]                  r_state, n_state;
    logic [btfa_pkg::CNT_W-1:0]  r_cnt, n_cnt;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_cnt   = '0;
                    n_state = (i_kind == btfa_pkg::KIND_MUL) ? ST_MUL : ST_PROP;
                end
            end
            ST_MUL: begin
                if (r_cnt == MUL_LAST) begin
                    n_cnt   = '0;
                    n_state = ST_PROP;
                end else begin
                    n_cnt = r_cnt + btfa_pkg::CNT_W'(1);
                end
            end
            ST_PROP: begin
                if (r_cnt == PROP_LAST) begin
                    n_cnt   = '0;
                    n_state = ST_DONE;
                end else begin
                    n_cnt = r_cnt + btfa_pkg::CNT_W'(1);
                end
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign busy            = (r_state != ST_IDLE);
    assign o_valid         = (r_state == ST_DONE);
    assign o_cmd.load      = (r_state == ST_IDLE) && start;
    assign o_cmd.mul_step  = (r_state == ST_MUL);
    assign o_cmd.prop_step = (r_state == ST_PROP);

    a_start_goes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && start) |=> (r_state == ST_MUL || r_state == ST_PROP))
        else $error("accepted request did not start work");

    a_mul_to_prop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL && r_cnt == MUL_LAST) |=> (r_state == ST_PROP && r_cnt == '0))
        else $error("multiply pass did not hand over to carry propagation");

    a_prop_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |-> ($past(r_state) == ST_PROP && $past(r_cnt) == PROP_LAST))
        else $error("result strobe without a full propagation pass");

    a_strobe_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> (!o_valid && !busy))
        else $error("result strobe longer than one cycle");

endmodule

// ----- hdl/btfa_dp.sv -----
// Datapath: operand alignment, carry-save trit multiply, sliced carry-propagate add.
module btfa_dp (
    input  logic                                i_clk,
    input  btfa_pkg::t_cmd                      i_cmd,
    input  logic [btfa_pkg::KIND_W-1:0]         i_kind,
    input  logic [btfa_pkg::MANT_W-1:0]         i_a_mant,
    input  logic signed [btfa_pkg::EXP_W-1:0]   i_a_exp,
    input  logic [btfa_pkg::MANT_W-1:0]         i_b_mant,
    input  logic signed [btfa_pkg::EXP_W-1:0]   i_b_exp,
    output logic [btfa_pkg::MANT_W-1:0]         o_res_mant,
    output logic signed [btfa_pkg::EXP_W-1:0]   o_res_exp,
    output logic                                o_overflow
);

    localparam int TW = 2 * btfa_pkg::TRITS;   // bits of one operand
    localparam int WW = 2 * btfa_pkg::WP;      // bits of the working vectors
    localparam int CW = 2 * btfa_pkg::CHUNK;   // bits of one propagate slice

    logic [WW-1:0]                     r_a, r_sum, r_car, r_res;
    logic [TW-1:0]                     r_b;
    logic [1:0]                        r_cin;
    logic signed [btfa_pkg::EXP_W-1:0] r_exp;

    logic [TW-1:0]                     na, nb, nneg, sha, shb;
    logic signed [btfa_pkg::EXP_W:0]   ediff, esum;
    logic [btfa_pkg::EXP_W:0]          dmag;
    logic                              a_gt, big;
    logic [btfa_pkg::SH_W:0]           shamt;
    logic signed [btfa_pkg::EXP_W-1:0] add_exp, mul_exp;

    logic [WW-1:0]                     pp, csa_s, csa_c;
    logic [CW-1:0]                     chunk;
    logic [1:0]                        cout;

    // operand decode, alignment and exponent
    always_comb begin
        for (int i = 0; i < btfa_pkg::TRITS; i++) begin
            na[2*i +: 2]   = btfa_pkg::trit_code(btfa_pkg::trit_val(i_a_mant[2*i +: 2]));
            nneg[2*i +: 2] = btfa_pkg::trit_neg(i_a_mant[2*i +: 2]);
            nb[2*i +: 2]   = (i_kind == btfa_pkg::KIND_SUB) ?
                             btfa_pkg::trit_neg(i_b_mant[2*i +: 2]) :
                             btfa_pkg::trit_code(btfa_pkg::trit_val(i_b_mant[2*i +: 2]));
        end
        ediff = (btfa_pkg::EXP_W+1)'(i_a_exp) - (btfa_pkg::EXP_W+1)'(i_b_exp);
        a_gt  = (ediff > 0);
        dmag  = a_gt ? unsigned'(ediff) : unsigned'(-ediff);
        big   = (dmag >= (btfa_pkg::EXP_W+1)'(btfa_pkg::TRITS));
        shamt = {dmag[btfa_pkg::SH_W-1:0], 1'b0};
        sha   = na;
        shb   = nb;
        if (a_gt) begin
            sha = big ? '0 : (na << shamt);
        end else begin
            shb = big ? '0 : (nb << shamt);
        end
        add_exp = a_gt ? i_b_exp : i_a_exp;
        esum    = (btfa_pkg::EXP_W+1)'(i_a_exp) + (btfa_pkg::EXP_W+1)'(i_b_exp);
        if (esum > 9'sd127) begin
            mul_exp = 8'sd127;
        end else if (esum < -9'sd128) begin
            mul_exp = -8'sd128;
        end else begin
            mul_exp = esum[btfa_pkg::EXP_W-1:0];
        end
    end

    // partial product and carry-save compression, no carry ripple
    always_comb begin
        btfa_pkg::t_digit d;
        csa_c = '0;
        for (int j = 0; j < btfa_pkg::WP; j++) begin
            if (r_b[1:0] == btfa_pkg::TRIT_POS) begin
                pp[2*j +: 2] = r_a[2*j +: 2];
            end else if (r_b[1:0] == btfa_pkg::TRIT_NEG) begin
                pp[2*j +: 2] = btfa_pkg::trit_neg(r_a[2*j +: 2]);
            end else begin
                pp[2*j +: 2] = btfa_pkg::TRIT_ZERO;
            end
            d = btfa_pkg::trit_split(btfa_pkg::trit_val(r_sum[2*j +: 2])
                                   + btfa_pkg::trit_val(r_car[2*j +: 2])
                                   + btfa_pkg::trit_val(pp[2*j +: 2]));
            csa_s[2*j +: 2] = d.t;
            if (j < btfa_pkg::WP - 1) begin
                csa_c[2*(j+1) +: 2] = d.k;
            end
        end
    end

    // one slice of the carry-propagate add
    always_comb begin
        btfa_pkg::t_digit d;
        logic [1:0] c;
        c = r_cin;
        for (int k = 0; k < btfa_pkg::CHUNK; k++) begin
            d = btfa_pkg::trit_split(btfa_pkg::trit_val(r_sum[2*k +: 2])
                                   + btfa_pkg::trit_val(r_car[2*k +: 2])
                                   + btfa_pkg::trit_val(c));
            chunk[2*k +: 2] = d.t;
            c = d.k;
        end
        cout = c;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a   <= WW'(na);
            r_b   <= nb;
            r_cin <= btfa_pkg::TRIT_ZERO;
            if (i_kind == btfa_pkg::KIND_MUL) begin
                r_sum <= '0;
                r_car <= '0;
                r_exp <= mul_exp;
            end else if (i_kind == btfa_pkg::KIND_NEG) begin
                r_sum <= WW'(nneg);
                r_car <= '0;
                r_exp <= i_a_exp;
            end else begin
                r_sum <= WW'(sha);
                r_car <= WW'(shb);
                r_exp <= add_exp;
            end
        end else if (i_cmd.mul_step) begin
            r_a   <= r_a << 2;
            r_b   <= r_b >> 2;
            r_sum <= csa_s;
            r_car <= csa_c;
        end else if (i_cmd.prop_step) begin
            r_sum <= r_sum >> CW;
            r_car <= r_car >> CW;
            r_cin <= cout;
            r_res <= {chunk, r_res[WW-1:CW]};
        end
    end

    assign o_res_mant = btfa_pkg::MANT_W'(r_res[TW-1:0]);
    assign o_res_exp  = r_exp;
    assign o_overflow = |r_res[WW-1:TW];

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking bench for balanced_ternary_float_alu_unit: directed and random requests.
module tb_top;

    localparam int CYCLE_LIMIT = 400_000;
    localparam int PRINT_CAP   = 30;

    localparam logic [btfa_pkg::MANT_W-1:0] ALL_POS  = 64'h5555_5555_5555_5555;
    localparam logic [btfa_pkg::MANT_W-1:0] ALL_NEG  = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [btfa_pkg::MANT_W-1:0] ALL_BAD  = 64'hAAAA_AAAA_AAAA_AAAA;
    localparam logic [btfa_pkg::MANT_W-1:0] TOP_POS  = 64'h4000_0000_0000_0000;
    localparam logic [btfa_pkg::MANT_W-1:0] LOW_POS  = 64'h0000_0000_0000_0001;

    typedef logic signed [127:0] t_wide;

    typedef struct {
        logic [btfa_pkg::MANT_W-1:0]        mant;
        logic signed [btfa_pkg::EXP_W-1:0]  expo;
        logic                               ovf;
    } t_alu_result;

    logic                                 i_clk;
    logic                                 i_rst_n;
    logic                                 start;
    logic                                 busy;
    logic [btfa_pkg::KIND_W-1:0]          req_kind;
    logic [btfa_pkg::MANT_W-1:0]          req_a_mant;
    logic signed [btfa_pkg::EXP_W-1:0]    req_a_exp;
    logic [btfa_pkg::MANT_W-1:0]          req_b_mant;
    logic signed [btfa_pkg::EXP_W-1:0]    req_b_exp;
    logic                                 o_valid;
    logic [btfa_pkg::MANT_W-1:0]          o_res_mant;
    logic signed [btfa_pkg::EXP_W-1:0]    o_res_exp;
    logic                                 o_overflow;

    int  cycle_count;
    bit  idle_on;

    balanced_ternary_float_alu_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_kind     (req_kind),
        .i_a_mant   (req_a_mant),
        .i_a_exp    (req_a_exp),
        .i_b_mant   (req_b_mant),
        .i_b_exp    (req_b_exp),
        .o_valid    (o_valid),
        .o_res_mant (o_res_mant),
        .o_res_exp  (o_res_exp),
        .o_overflow (o_overflow)
    );

    class alu_scoreboard;
        t_alu_result expected_q[$];
        int n_errors;
        int n_checked;
        int n_overflow;
        int kind_count[4];

        function new();
            n_errors   = 0;
            n_checked  = 0;
            n_overflow = 0;
            foreach (kind_count[i]) kind_count[i] = 0;
        endfunction

        // integer value of a mantissa; code 10 reads as zero
        static function t_wide mant_value(input logic [btfa_pkg::MANT_W-1:0] m);
            t_wide v;
            t_wide w;
            v = 0;
            w = 1;
            for (int i = 0; i < btfa_pkg::TRITS; i++) begin
                if (m[2*i +: 2] == btfa_pkg::TRIT_POS) begin
                    v = v + w;
                end else if (m[2*i +: 2] == btfa_pkg::TRIT_NEG) begin
                    v = v - w;
                end
                w = w * 3;
            end
            return v;
        endfunction

        // shift up by d trits, top trits fall off
        static function logic [btfa_pkg::MANT_W-1:0] align_up(
                input logic [btfa_pkg::MANT_W-1:0] m, input int d);
            if (d >= btfa_pkg::TRITS) begin
                return '0;
            end
            return m << (2 * d);
        endfunction

        // low TRITS balanced digits of v; anything left over is overflow
        static function void to_trits(input t_wide v,
                                      output logic [btfa_pkg::MANT_W-1:0] mant,
                                      output logic ovf);
            t_wide r;
            mant = '0;
            for (int i = 0; i < btfa_pkg::TRITS; i++) begin
                r = v % 3;
                if (r < 0) r = r + 3;
                if (r == 1) begin
                    mant[2*i +: 2] = btfa_pkg::TRIT_POS;
                    v = (v - 1) / 3;
                end else if (r == 2) begin
                    mant[2*i +: 2] = btfa_pkg::TRIT_NEG;
                    v = (v + 1) / 3;
                end else begin
                    v = v / 3;
                end
            end
            ovf = (v != 0);
        endfunction

        static function t_alu_result predict_result(input logic [btfa_pkg::KIND_W-1:0] kind,
                input logic [btfa_pkg::MANT_W-1:0] am,
                input logic signed [btfa_pkg::EXP_W-1:0] ae,
                input logic [btfa_pkg::MANT_W-1:0] bm,
                input logic signed [btfa_pkg::EXP_W-1:0] be);
            t_alu_result r;
            t_wide       va;
            t_wide       vb;
            t_wide       total;
            int          e;
            if (kind == btfa_pkg::KIND_NEG) begin
                total = -mant_value(am);
                e = ae;
            end else if (kind == btfa_pkg::KIND_MUL) begin
                total = mant_value(am) * mant_value(bm);
                e = int'(ae) + int'(be);
                if (e > 127) e = 127;
                if (e < -128) e = -128;
            end else begin
                if (ae > be) begin
                    va = mant_value(align_up(am, int'(ae) - int'(be)));
                    vb = mant_value(bm);
                    e = be;
                end else begin
                    va = mant_value(am);
                    vb = mant_value(align_up(bm, int'(be) - int'(ae)));
                    e = ae;
                end
                if (kind == btfa_pkg::KIND_SUB) vb = -vb;
                total = va + vb;
            end
            to_trits(total, r.mant, r.ovf);
            r.expo = btfa_pkg::EXP_W'(e);
            return r;
        endfunction

        function void note_request(input logic [btfa_pkg::KIND_W-1:0] kind,
                input logic [btfa_pkg::MANT_W-1:0] am,
                input logic signed [btfa_pkg::EXP_W-1:0] ae,
                input logic [btfa_pkg::MANT_W-1:0] bm,
                input logic signed [btfa_pkg::EXP_W-1:0] be);
            expected_q.push_back(predict_result(kind, am, ae, bm, be));
            kind_count[kind]++;
        endfunction

        task report_mismatch(input string what, input logic [btfa_pkg::MANT_W-1:0] got,
                             input logic [btfa_pkg::MANT_W-1:0] want);
            if (n_errors < PRINT_CAP) begin
                $display("[%0t] MISMATCH %s: got %h expected %h", $time, what, got, want);
            end
            n_errors++;
        endtask

        task check_result(input logic [btfa_pkg::MANT_W-1:0] mant,
                          input logic signed [btfa_pkg::EXP_W-1:0] expo,
                          input logic ovf);
            t_alu_result want;
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result", mant, '0);
            end else begin
                want = expected_q.pop_front();
                n_checked++;
                if (want.ovf) n_overflow++;
                if (mant !== want.mant) report_mismatch("res_mant", mant, want.mant);
                if (expo !== want.expo)
                    report_mismatch("res_exp", btfa_pkg::MANT_W'(unsigned'(expo)),
                                    btfa_pkg::MANT_W'(unsigned'(want.expo)));
                if (ovf !== want.ovf)
                    report_mismatch("overflow", btfa_pkg::MANT_W'(ovf),
                                    btfa_pkg::MANT_W'(want.ovf));
            end
        endtask
    endclass

    alu_scoreboard sb = new();

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // pre-edge values: inputs move on the falling edge, outputs on NBA
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid) sb.check_result(o_res_mant, o_res_exp, o_overflow);
            if (start && !busy)
                sb.note_request(req_kind, req_a_mant, req_a_exp, req_b_mant, req_b_exp);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, sb.expected_q.size());
            $display("balanced_ternary_float_alu_unit verification failed");
            $finish;
        end
    end

    function automatic logic [btfa_pkg::MANT_W-1:0] rand_mant();
        logic [btfa_pkg::MANT_W-1:0] m;
        int sel;
        int lim;
        int r;
        sel = $urandom_range(0, 3);
        m = '0;
        if (sel == 0) begin
            m = {$urandom, $urandom};
        end else begin
            lim = (sel == 2) ? $urandom_range(1, btfa_pkg::TRITS) : btfa_pkg::TRITS;
            for (int i = 0; i < lim; i++) begin
                r = $urandom_range(0, (sel == 3) ? 15 : 2);
                if (r == 1) m[2*i +: 2] = btfa_pkg::TRIT_POS;
                else if (r == 2) m[2*i +: 2] = btfa_pkg::TRIT_NEG;
            end
        end
        return m;
    endfunction

    task automatic send_req(input logic [btfa_pkg::KIND_W-1:0] kind,
                            input logic [btfa_pkg::MANT_W-1:0] am, input int ae,
                            input logic [btfa_pkg::MANT_W-1:0] bm, input int be);
        @(negedge i_clk);
        // idle only once the block is ready again, so gaps show up on the interface
        while (busy) @(negedge i_clk);
        while (idle_on && $urandom_range(0, 99) < 23) begin
            start      <= 1'b0;
            req_kind   <= btfa_pkg::KIND_W'($urandom);
            req_a_mant <= {$urandom, $urandom};
            req_a_exp  <= btfa_pkg::EXP_W'($urandom);
            req_b_mant <= {$urandom, $urandom};
            req_b_exp  <= btfa_pkg::EXP_W'($urandom);
            @(negedge i_clk);
        end
        start      <= 1'b1;
        req_kind   <= kind;
        req_a_mant <= am;
        req_a_exp  <= btfa_pkg::EXP_W'(ae);
        req_b_mant <= bm;
        req_b_exp  <= btfa_pkg::EXP_W'(be);
        do @(posedge i_clk); while (busy);
    endtask

    // hold off new requests until every outstanding result is back
    task automatic drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        logic [btfa_pkg::KIND_W-1:0] kind;
        int ae;
        int be;

        cycle_count = 0;
        idle_on     = 1'b1;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        req_kind    = btfa_pkg::KIND_ADD;
        req_a_mant  = '0;
        req_a_exp   = '0;
        req_b_mant  = '0;
        req_b_exp   = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed corners
        send_req(btfa_pkg::KIND_ADD, '0, 0, '0, 0);
        send_req(btfa_pkg::KIND_ADD, ALL_POS, 0, ALL_POS, 0);       // carry out of top trit
        send_req(btfa_pkg::KIND_ADD, ALL_NEG, 5, ALL_NEG, 5);
        send_req(btfa_pkg::KIND_ADD, TOP_POS, -3, TOP_POS, -3);
        send_req(btfa_pkg::KIND_SUB, ALL_POS, 7, ALL_POS, 7);       // a - a
        send_req(btfa_pkg::KIND_SUB, ALL_POS, 0, ALL_NEG, 0);
        send_req(btfa_pkg::KIND_ADD, ALL_BAD, 1, LOW_POS, 1);       // code 10 is zero
        send_req(btfa_pkg::KIND_ADD, LOW_POS, 127, ALL_POS, -128);  // alignment clears a
        send_req(btfa_pkg::KIND_SUB, ALL_NEG, -128, LOW_POS, 127);
        send_req(btfa_pkg::KIND_ADD, LOW_POS, 31, LOW_POS, 0);      // shift to the top trit
        send_req(btfa_pkg::KIND_ADD, LOW_POS, 0, ALL_POS, 32);      // shift of TRITS
        send_req(btfa_pkg::KIND_ADD, ALL_POS, 4, LOW_POS, 1);
        send_req(btfa_pkg::KIND_NEG, ALL_POS, 127, ALL_BAD, 3);
        send_req(btfa_pkg::KIND_NEG, ALL_BAD, -128, ALL_NEG, -128);
        send_req(btfa_pkg::KIND_NEG, 64'h1D73_5C9E_07B4_F1A3, -1, '0, 0);
        send_req(btfa_pkg::KIND_MUL, ALL_POS, 0, ALL_POS, 0);
        send_req(btfa_pkg::KIND_MUL, ALL_NEG, 127, ALL_POS, 127);   // exponent saturates high
        send_req(btfa_pkg::KIND_MUL, ALL_POS, -128, ALL_NEG, -128); // and low
        send_req(btfa_pkg::KIND_MUL, ALL_POS, 9, '0, -9);
        send_req(btfa_pkg::KIND_MUL, LOW_POS, 100, ALL_BAD, 100);
        send_req(btfa_pkg::KIND_MUL, 64'h0000_0000_0005_5555, 2,
                 64'h0000_0000_000F_FFFF, -2);
        send_req(btfa_pkg::KIND_MUL, TOP_POS, -60, TOP_POS, -70);
        drain();

        for (int n = 0; n < 1100; n++) begin
            idle_on = !(n >= 400 && n < 650);
            if (n == 700) drain();
            kind = btfa_pkg::KIND_W'($urandom_range(0, 3));
            if ($urandom_range(0, 9) < 7) begin
                ae = int'($urandom_range(0, 255)) - 128;
                be = ae + int'($urandom_range(0, 80)) - 40;
                if (be > 127) be = 127;
                if (be < -128) be = -128;
            end else begin
                ae = int'($urandom_range(0, 255)) - 128;
                be = int'($urandom_range(0, 255)) - 128;
            end
            send_req(kind, rand_mant(), ae, rand_mant(), be);
        end

        drain();
        repeat (60) @(posedge i_clk);

        $display("covered %0d add, %0d sub, %0d negate, %0d multiply requests",
                 sb.kind_count[btfa_pkg::KIND_ADD], sb.kind_count[btfa_pkg::KIND_SUB],
                 sb.kind_count[btfa_pkg::KIND_NEG], sb.kind_count[btfa_pkg::KIND_MUL]);
        $display("%0d results checked, %0d with mantissa overflow, %0d mismatches",
                 sb.n_checked, sb.n_overflow, sb.n_errors);
        if (sb.n_errors == 0) begin
            $display("balanced_ternary_float_alu_unit verification clean");
        end else begin
            $display("balanced_ternary_float_alu_unit verification failed");
        end
        $finish;
    end

endmodule
